// ===== sv/ssm_pkg.sv =====
// Shared types, constants and the seven-segment font for the two-digit display driver.
// No dependencies; every other file of the block refers to this package by scoped name.
package ssm_pkg;

  localparam int unsigned ValueW  = 8;
  localparam int unsigned SegW    = 7;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned HalfW   = 15;
  localparam int unsigned CountW  = 16;
  localparam int unsigned TolW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ValueW-1:0] MaxShown = 8'd99;
  localparam logic [HalfW-1:0]  HalfPeriodReset = 15'd50;
  localparam logic [TolW-1:0]   ToleranceReset  = 8'd2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgFlashHalfPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTolerance       = 2'd1;

  localparam logic [SegW-1:0] SegBlank = 7'h00;
  localparam logic [SegW-1:0] SegZero  = 7'h3F;

  // Segment pattern for one decimal digit, bit 0 is segment a.
  function automatic logic [SegW-1:0] seg_font(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] pattern;
    case (digit)
      4'd0: pattern = 7'h3F;
      4'd1: pattern = 7'h06;
      4'd2: pattern = 7'h5B;
      4'd3: pattern = 7'h4F;
      4'd4: pattern = 7'h66;
      4'd5: pattern = 7'h6D;
      4'd6: pattern = 7'h7D;
      4'd7: pattern = 7'h07;
      4'd8: pattern = 7'h7F;
      4'd9: pattern = 7'h6F;
      default: pattern = SegBlank;
    endcase
    return pattern;
  endfunction

endpackage

// ===== sv/ssm_encode.sv =====
// Digit split and segment encoding for the two-digit display driver.
// Depends on ssm_pkg for widths and the segment font.
module ssm_encode (
  input  logic [ssm_pkg::ValueW-1:0] value_i,
  input  logic                       units_phase_i,
  output logic [ssm_pkg::SegW-1:0]   segments_o
);

  logic [ssm_pkg::ValueW-1:0]   sat;
  logic [15:0]                  scaled;
  logic [ssm_pkg::DigitW-1:0]   tens;
  logic [ssm_pkg::ValueW-1:0]   tens_x10;
  logic [ssm_pkg::ValueW-1:0]   units_full;
  logic [ssm_pkg::DigitW-1:0]   units;

  always_comb begin
    sat = (value_i > ssm_pkg::MaxShown) ? ssm_pkg::MaxShown : value_i;
    // Division by ten through the reciprocal 205/2048, exact for values up to 99.
    scaled     = {8'd0, sat} * 16'd205;
    tens       = scaled[14:11];
    tens_x10   = {4'd0, tens} * 8'd10;
    units_full = sat - tens_x10;
    units      = units_full[ssm_pkg::DigitW-1:0];
    if (units_phase_i) begin
      segments_o = ssm_pkg::seg_font(units);
    end else if (tens == 4'd0) begin
      segments_o = ssm_pkg::SegBlank;
    end else begin
      segments_o = ssm_pkg::seg_font(tens);
    end
  end

endmodule

// ===== sv/two_digit_seven_segment_mux_unit.sv =====
// Top level of the multiplexed two-digit seven-segment display driver.
// Depends on ssm_pkg and ssm_encode.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   shown_value, regulator_on, setpoint, measured
//   result    out        out_valid_o / out_stall_i segments, point_lit, digit_select
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request passes through two registers: accepting it loads the input register, and the
// request moves on into the result register, whose outputs drive the result channel, when that
// register is empty or being drained. One request is taken in every cycle while the result side
// keeps up. After reset the phase is at tens, so the first result drives the units digit, and
// the flash counter is zero. When the result side stalls, one further request is still taken
// into the input register; only with both registers full is in_stall_o raised. Configuration
// writes are always taken.
module two_digit_seven_segment_mux_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ssm_pkg::ValueW-1:0]   shown_value_i,
  input  logic                         regulator_on_i,
  input  logic [ssm_pkg::ValueW-1:0]   setpoint_i,
  input  logic [ssm_pkg::ValueW-1:0]   measured_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ssm_pkg::SegW-1:0]     segments_o,
  output logic                         point_lit_o,
  output logic                         digit_select_o,
  // Configuration channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ssm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ssm_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [ssm_pkg::HalfW-1:0] half_q;
  logic [ssm_pkg::TolW-1:0]  tol_q;

  // Input register.
  logic                       in_valid_q;
  logic [ssm_pkg::ValueW-1:0] value_q;
  logic                       reg_on_q;
  logic [ssm_pkg::ValueW-1:0] setpoint_q;
  logic [ssm_pkg::ValueW-1:0] measured_q;

  // Display state.
  logic                       phase_q;
  logic                       phase_d;
  logic [ssm_pkg::CountW-1:0] flash_q;
  logic [ssm_pkg::CountW-1:0] flash_d;

  // Result register.
  logic                       res_valid_q;
  logic [ssm_pkg::SegW-1:0]   segments_q;
  logic                       point_q;
  logic                       select_q;

  logic                       advance;
  logic                       load_res;
  logic                       in_accept;
  logic [ssm_pkg::SegW-1:0]   segments_d;
  logic                       point_d;
  logic [ssm_pkg::ValueW:0]   diff;
  logic                       on_target;
  logic [ssm_pkg::CountW-1:0] flash_inc;

  // The result register can take a new value when it is empty or being drained.
  assign advance   = !res_valid_q || !out_stall_i;
  assign load_res  = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= ssm_pkg::HalfPeriodReset;
      tol_q  <= ssm_pkg::ToleranceReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssm_pkg::CfgFlashHalfPeriod: half_q <= cfg_data_i[ssm_pkg::HalfW-1:0];
        ssm_pkg::CfgTolerance:       tol_q  <= cfg_data_i[ssm_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (load_res) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      value_q    <= shown_value_i;
      reg_on_q   <= regulator_on_i;
      setpoint_q <= setpoint_i;
      measured_q <= measured_i;
    end
  end

  ssm_encode u_encode (
    .value_i       (value_q),
    .units_phase_i (phase_d),
    .segments_o    (segments_d)
  );

  // The phase flips for every request; the decimal point only matters in the units phase, where
  // an active regulator that sits within tolerance of its setpoint makes the point flash.
  always_comb begin
    phase_d   = !phase_q;
    diff      = (setpoint_q >= measured_q) ? ({1'b0, setpoint_q} - {1'b0, measured_q})
                                           : ({1'b0, measured_q} - {1'b0, setpoint_q});
    on_target = diff <= {1'b0, tol_q};
    flash_inc = flash_q + 16'd1;
    flash_d   = flash_q;
    point_d   = 1'b0;
    if (phase_d) begin
      if (reg_on_q && on_target) begin
        point_d = flash_inc >= {1'b0, half_q};
        // The counter wraps once it reaches twice the half-period, also when the half-period
        // was lowered below the current count.
        if ({1'b0, flash_inc} >= {1'b0, half_q, 1'b0}) begin
          flash_d = '0;
        end else begin
          flash_d = flash_inc;
        end
      end else begin
        point_d = reg_on_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      flash_q     <= '0;
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
      if (in_valid_q) begin
        phase_q <= phase_d;
        flash_q <= flash_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      segments_q <= segments_d;
      point_q    <= point_d;
      select_q   <= phase_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign segments_o     = segments_q;
  assign point_lit_o    = point_q;
  assign digit_select_o = select_q;

  // The phase moves exactly when a request passes into the result register.
  a_phase_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> phase_q != $past(phase_q))
    else $error("phase did not toggle on a result load");

  a_phase_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_res |=> $stable(phase_q) && $stable(flash_q))
    else $error("display state changed without a result load");

  // The shown digit selection follows the phase that the result was built with.
  a_select_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_res |=> digit_select_o == phase_q)
    else $error("digit selection differs from the phase");

  // Tens phase never lights the point and never shows a leading zero.
  a_tens_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !digit_select_o) |-> (!point_lit_o && segments_o != ssm_pkg::SegZero))
    else $error("tens digit shows a point or a leading zero");

  // Flash counter stays unchanged in the tens phase.
  a_flash_tens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_res && !phase_d) |=> $stable(flash_q))
    else $error("flash counter moved in the tens phase");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-digit multiplexed seven-segment display driver.
// Depends on ssm_pkg and the two_digit_seven_segment_mux_unit RTL; nothing else.
module tb_top;

  // Clock period is 2 ns. Reset is held at the start and never again.
  localparam int unsigned ResetCycles = 9;
  // The block holds at most two requests in flight, in its input and result registers.
  localparam int unsigned SettleCycles = 4;
  // Length of the long receiver hold-off that fills the block and forces in_stall_o high.
  localparam int unsigned HoldCycles = 40;
  // Roughly 900 requests in all; this limit is far beyond what they take in the slowest case.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportLimit = 10;

  // Segment patterns for the decimal digits, bit 0 is segment a.
  localparam logic [ssm_pkg::SegW-1:0] GlyphRom [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // One display drive as it leaves the block.
  typedef struct packed {
    logic [ssm_pkg::SegW-1:0] seg;
    logic                     point;
    logic                     digit_sel;
  } drive_t;

  // One row of the directed stimulus. Where hand_set is high the drive is typed in below;
  // otherwise it is left to the display model.
  typedef struct packed {
    logic [ssm_pkg::ValueW-1:0] value;
    logic                       reg_on;
    logic [ssm_pkg::ValueW-1:0] setpoint;
    logic [ssm_pkg::ValueW-1:0] measured;
    logic                       hand_set;
    drive_t                     drive;
  } tick_row_t;

  // One random section: the register contents written before it, its length in requests,
  // whether idling is switched off on both sides, and whether the receiver holds off for long.
  typedef struct packed {
    logic [ssm_pkg::CfgDataW-1:0] half_data;
    logic [ssm_pkg::CfgDataW-1:0] tol_data;
    logic [9:0]                   requests;
    logic                         quiet;
    logic                         squeeze;
  } section_t;

  localparam int unsigned RowCount = 22;
  localparam int unsigned SectionCount = 8;

  // The first row after reset drives the units digit, and the rows then alternate between
  // units and tens. Registers are at their reset values here: half-period 50, tolerance 2.
  tick_row_t tick_rows [RowCount] = '{
    // Regulator off while on target: the point stays dark, the counter does not move.
    '{8'd0,   1'b0, 8'd0,   8'd0,   1'b1, '{7'h3F, 1'b0, 1'b1}},
    // A zero tens digit is blanked.
    '{8'd0,   1'b0, 8'd0,   8'd0,   1'b1, '{7'h00, 1'b0, 1'b0}},
    // Top of the input range saturates to 99; off target, so the point follows the flag.
    '{8'd255, 1'b1, 8'd0,   8'd255, 1'b1, '{7'h6F, 1'b1, 1'b1}},
    // Tens phase keeps the point dark even when flashing would apply.
    '{8'd255, 1'b1, 8'd255, 8'd255, 1'b1, '{7'h6F, 1'b0, 1'b0}},
    // First flash tick: the count is one, well below the half-period, so the point is dark.
    '{8'd100, 1'b1, 8'd20,  8'd22,  1'b1, '{7'h6F, 1'b0, 1'b1}},
    '{8'd10,  1'b1, 8'd22,  8'd20,  1'b1, '{7'h06, 1'b0, 1'b0}},
    '{8'd7,   1'b1, 8'd22,  8'd20,  1'b1, '{7'h07, 1'b0, 1'b1}},
    '{8'd57,  1'b0, 8'd128, 8'd127, 1'b1, '{7'h6D, 1'b0, 1'b0}},
    // One step outside the tolerance: no flashing, the point is simply lit.
    '{8'd99,  1'b1, 8'd10,  8'd13,  1'b1, '{7'h6F, 1'b1, 1'b1}},
    '{8'd42,  1'b1, 8'd13,  8'd10,  1'b1, '{7'h66, 1'b0, 1'b0}},
    '{8'd12,  1'b1, 8'd200, 8'd201, 1'b0, '0},
    '{8'd23,  1'b0, 8'd0,   8'd0,   1'b0, '0},
    '{8'd34,  1'b1, 8'd1,   8'd0,   1'b0, '0},
    '{8'd36,  1'b1, 8'd0,   8'd200, 1'b0, '0},
    '{8'd56,  1'b0, 8'd255, 8'd0,   1'b0, '0},
    '{8'd68,  1'b1, 8'd127, 8'd128, 1'b0, '0},
    '{8'd78,  1'b1, 8'd85,  8'd87,  1'b0, '0},
    '{8'd81,  1'b1, 8'd85,  8'd88,  1'b0, '0},
    '{8'd90,  1'b1, 8'd0,   8'd0,   1'b0, '0},
    '{8'd70,  1'b0, 8'd64,  8'd66,  1'b0, '0},
    '{8'd13,  1'b1, 8'd170, 8'd85,  1'b0, '0},
    '{8'd65,  1'b1, 8'd85,  8'd170, 1'b0, '0}
  };

  // The half-period runs from its extremes through zero and back. A very long half-period
  // lets the count build up, and the short one after it is then below the count, which must
  // light the point and clear the count on the next flash tick. The section with upper bits
  // set in the written data checks that only the register width is kept.
  section_t sections [SectionCount] = '{
    '{16'd3,     16'd0,     10'd100, 1'b0, 1'b1},
    '{16'd1,     16'd255,   10'd80,  1'b0, 1'b0},
    '{16'd32767, 16'd255,   10'd60,  1'b0, 1'b0},
    '{16'd10,    16'd6,     10'd120, 1'b0, 1'b0},
    '{16'd0,     16'd3,     10'd60,  1'b0, 1'b0},
    '{16'h8005,  16'h1F07,  10'd120, 1'b1, 1'b1},
    '{16'd2,     16'd1,     10'd150, 1'b0, 1'b0},
    '{16'd7,     16'd20,    10'd160, 1'b0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [ssm_pkg::ValueW-1:0]   shown_value_i;
  logic                         regulator_on_i;
  logic [ssm_pkg::ValueW-1:0]   setpoint_i;
  logic [ssm_pkg::ValueW-1:0]   measured_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [ssm_pkg::SegW-1:0]     segments_o;
  logic                         point_lit_o;
  logic                         digit_select_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [ssm_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [ssm_pkg::CfgDataW-1:0] cfg_data_i;

  // Display model state: register copies, the digit phase and the flash counter.
  logic [ssm_pkg::HalfW-1:0]  half_period_q;
  logic [ssm_pkg::TolW-1:0]   tolerance_q;
  logic                       digit_phase_q;
  logic [ssm_pkg::CountW-1:0] flash_count_q;

  // Drives still owed by the block, oldest first.
  drive_t owed_drives [$];

  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_quiet = 1'b0;
  logic        receiver_quiet;
  int unsigned hold_asks;
  int unsigned hold_served = 0;

  two_digit_seven_segment_mux_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .shown_value_i  (shown_value_i),
    .regulator_on_i (regulator_on_i),
    .setpoint_i     (setpoint_i),
    .measured_i     (measured_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .point_lit_o    (point_lit_o),
    .digit_select_o (digit_select_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Works out the drive for one accepted request and advances the model state. The phase
  // toggles first, so the first request after reset lands in the units phase. The counter
  // only moves on units-phase ticks where the regulator is on and the reading is on target.
  function automatic drive_t display_tick(input logic [ssm_pkg::ValueW-1:0] value,
                                          input logic reg_on,
                                          input logic [ssm_pkg::ValueW-1:0] setpoint,
                                          input logic [ssm_pkg::ValueW-1:0] measured);
    int unsigned clipped;
    int unsigned tens;
    int unsigned units;
    int unsigned gap;
    drive_t      result;
    clipped = (value > 8'd99) ? 99 : int'(value);
    tens = clipped / 10;
    units = clipped % 10;
    gap = (setpoint >= measured) ? int'(setpoint - measured) : int'(measured - setpoint);
    digit_phase_q = ~digit_phase_q;
    result.digit_sel = digit_phase_q;
    result.point = 1'b0;
    if (!digit_phase_q) begin
      result.seg = (tens == 0) ? '0 : GlyphRom[tens];
    end else begin
      result.seg = GlyphRom[units];
      if (reg_on && gap <= int'(tolerance_q)) begin
        flash_count_q = flash_count_q + 16'd1;
        result.point = (int'(flash_count_q) >= int'(half_period_q));
        // Reaching twice the half-period, or having been left above it by a smaller
        // half-period, clears the count; a zero half-period clears it on every tick.
        if (int'(flash_count_q) >= 2 * int'(half_period_q)) begin
          flash_count_q = '0;
        end
      end else begin
        result.point = reg_on;
      end
    end
    return result;
  endfunction

  // Offers one request and waits for it to be taken. Entered and left at a falling edge.
  // The valid line is only lowered for a random gap, so back-to-back requests keep it high.
  task automatic offer_request(input logic [ssm_pkg::ValueW-1:0] value, input logic reg_on,
                               input logic [ssm_pkg::ValueW-1:0] setpoint,
                               input logic [ssm_pkg::ValueW-1:0] measured,
                               input logic hand_set, input drive_t hand_drive);
    drive_t modelled;
    while (!sender_quiet && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    shown_value_i  <= value;
    regulator_on_i <= reg_on;
    setpoint_i     <= setpoint;
    measured_i     <= measured;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    modelled = display_tick(value, reg_on, setpoint, measured);
    owed_drives.push_back(hand_set ? hand_drive : modelled);
    @(negedge clk_i);
  endtask

  // Builds a random request. Most are in range, most have the regulator on and most read
  // near the setpoint to exercise flashing hard; the rest cover saturation and the full input range.
  task automatic offer_random_request();
    logic [ssm_pkg::ValueW-1:0] value;
    logic                       reg_on;
    logic [ssm_pkg::ValueW-1:0] setpoint;
    logic [ssm_pkg::ValueW-1:0] measured;
    int                         offset;
    int                         level;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: value = 8'($urandom_range(99));
      6, 7:             value = 8'($urandom_range(255, 100));
      default:          value = 8'($urandom_range(255));
    endcase
    reg_on = ($urandom_range(9) < 8);
    setpoint = 8'($urandom_range(255));
    if ($urandom_range(9) < 6) begin
      // Near the setpoint: within the tolerance or one step outside it.
      offset = $urandom_range(int'(tolerance_q) + 1);
      level = $urandom_range(1) ? int'(setpoint) + offset : int'(setpoint) - offset;
      if (level > 255) begin
        level = 255;
      end else if (level < 0) begin
        level = 0;
      end
      measured = level[ssm_pkg::ValueW-1:0];
    end else begin
      measured = 8'($urandom_range(255));
    end
    offer_request(value, reg_on, setpoint, measured, 1'b0, '0);
  endtask

  // Writes one register and updates the model copy. Only the register width is kept.
  // The valid line is left high so that writes can follow back to back; the caller lowers it.
  task automatic write_register(input logic [ssm_pkg::CfgIdxW-1:0] index,
                                input logic [ssm_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    if (index == ssm_pkg::CfgFlashHalfPeriod) begin
      half_period_q = data[ssm_pkg::HalfW-1:0];
    end else if (index == ssm_pkg::CfgTolerance) begin
      tolerance_q = data[ssm_pkg::TolW-1:0];
    end
    @(negedge clk_i);
  endtask

  // Stops offering requests and waits until every owed drive has come out, then lets the
  // pipeline settle so that the block is idle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (owed_drives.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Result side. A pending hold-off request from the stimulus makes the receiver stall for
  // a long stretch, counted here, while the sender keeps offering; the block then fills its
  // two registers and raises in_stall_o. Otherwise it stalls now and then at random.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_asks) begin
        hold_served++;
        repeat (HoldCycles) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= !receiver_quiet && ($urandom_range(99) < 15);
    end
  end

  // Every drive the block hands over is compared field by field with the oldest one owed.
  always @(posedge clk_i) begin : drive_check
    drive_t owed;
    drive_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{segments_o, point_lit_o, digit_select_o};
      if (owed_drives.size() == 0) begin
        fault_count++;
        if (fault_count <= ReportLimit) begin
          $display("unexpected drive: seg=%h point=%b sel=%b", seen.seg, seen.point,
                   seen.digit_sel);
        end
      end else begin
        owed = owed_drives.pop_front();
        if (seen.seg !== owed.seg || seen.point !== owed.point ||
            seen.digit_sel !== owed.digit_sel) begin
          fault_count++;
          if (fault_count <= ReportLimit) begin
            $display("drive mismatch: seg %h/%h point %b/%b sel %b/%b (expected/actual)",
                     owed.seg, seen.seg, owed.point, seen.point, owed.digit_sel,
                     seen.digit_sel);
          end
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[two_digit_seven_segment_mux_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    shown_value_i  = '0;
    regulator_on_i = 1'b0;
    setpoint_i     = '0;
    measured_i     = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = ssm_pkg::CfgFlashHalfPeriod;
    cfg_data_i     = '0;
    receiver_quiet = 1'b0;
    hold_asks      = 0;
    half_period_q  = ssm_pkg::HalfPeriodReset;
    tolerance_q    = ssm_pkg::ToleranceReset;
    digit_phase_q  = 1'b0;
    flash_count_q  = '0;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows, with the registers still at their reset values.
    for (int r = 0; r < RowCount; r++) begin
      offer_request(tick_rows[r].value, tick_rows[r].reg_on, tick_rows[r].setpoint,
                    tick_rows[r].measured, tick_rows[r].hand_set, tick_rows[r].drive);
    end

    // Random sections, each preceded by register writes while the block is idle.
    for (int s = 0; s < SectionCount; s++) begin
      drain_block();
      write_register(ssm_pkg::CfgFlashHalfPeriod, sections[s].half_data);
      write_register(ssm_pkg::CfgTolerance, sections[s].tol_data);
      cfg_valid_i <= 1'b0;
      sender_quiet = sections[s].quiet;
      receiver_quiet <= sections[s].quiet;
      if (sections[s].squeeze) begin
        hold_asks <= hold_asks + 1;
      end
      for (int n = 0; n < int'(sections[s].requests); n++) begin
        offer_random_request();
      end
    end

    drain_block();
    fault_count += owed_drives.size();
    if (fault_count == 0) begin
      $display("[two_digit_seven_segment_mux_unit] OK");
    end else begin
      $display("[two_digit_seven_segment_mux_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ssm_pkg.sv
sv/ssm_encode.sv
sv/two_digit_seven_segment_mux_unit.sv
verif/tb_top.sv
